// ===== src/rnc14_pkg.sv =====
// Shared types, controller codes and constants of the RPN/NRPN/CC14 assembler.
package rnc14_pkg;

  // Default number of channel slots
  localparam int CHANNELS_DEF = 16;
  // Width of a MIDI channel number and of a 7-bit MIDI data byte
  localparam int CH_BITS = 4;
  localparam int BYTE_BITS = 7;
  localparam int WORD_BITS = 2 * BYTE_BITS;
  // Pieces one slot access can produce: four slot pieces and one pass-through
  localparam int NPIECES = 5;
  localparam int PASS_IDX = NPIECES - 1;

  // Controller numbers
  localparam logic [BYTE_BITS-1:0] CTL_RPN_MSB  = 7'h65;
  localparam logic [BYTE_BITS-1:0] CTL_RPN_LSB  = 7'h64;
  localparam logic [BYTE_BITS-1:0] CTL_NRPN_MSB = 7'h63;
  localparam logic [BYTE_BITS-1:0] CTL_NRPN_LSB = 7'h62;
  localparam logic [BYTE_BITS-1:0] CTL_DATA_MSB = 7'h06;
  localparam logic [BYTE_BITS-1:0] CTL_DATA_LSB = 7'h26;
  localparam logic [BYTE_BITS-1:0] CC14_LSB_OFS = 7'h20;

  typedef enum logic {
    OP_EVENT = 1'b0,
    OP_FLUSH = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    TYPE_NONE = 2'd0,
    TYPE_RPN  = 2'd1,
    TYPE_NRPN = 2'd2,
    TYPE_CC14 = 2'd3
  } slot_type_t;

  typedef enum logic [1:0] {
    KIND_CC   = 2'd0,
    KIND_RPN  = 2'd1,
    KIND_NRPN = 2'd2,
    KIND_CC14 = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_FEVAL,
    ST_EMIT
  } state_t;

  // One channel slot: 34 bits
  typedef struct packed {
    slot_type_t typ;
    logic pm_v;
    logic pl_v;
    logic vm_v;
    logic vl_v;
    logic [BYTE_BITS-1:0] pm;
    logic [BYTE_BITS-1:0] pl;
    logic [BYTE_BITS-1:0] vm;
    logic [BYTE_BITS-1:0] vl;
  } slot_t;

  // One emitted event, channel excluded
  typedef struct packed {
    kind_t kind;
    logic [WORD_BITS-1:0] param;
    logic [WORD_BITS-1:0] value;
  } piece_t;

  typedef struct packed {
    piece_t [NPIECES-1:0] p;
    logic [NPIECES-1:0] mask;
  } piece_list_t;

  // Slot write-back request
  typedef struct packed {
    logic wr_en;
    logic clr;
    slot_t wdata;
  } upd_t;

endpackage

// ===== src/rnc14_slot_mem.sv =====
// Channel slot memory: synchronous RAM with registered read and per-entry valid bits.
module rnc14_slot_mem #(
  parameter int CHANNELS = rnc14_pkg::CHANNELS_DEF
) (
  input  logic                                              clk,
  input  logic                                              rst,
  input  logic [((CHANNELS > 1) ? $clog2(CHANNELS) : 1)-1:0] rd_addr,
  input  logic                                              wr_en,
  input  logic                                              clr_en,
  input  logic [((CHANNELS > 1) ? $clog2(CHANNELS) : 1)-1:0] wr_addr,
  input  rnc14_pkg::slot_t                                  wr_data,
  output rnc14_pkg::slot_t                                  rd_data,
  output logic [CHANNELS-1:0]                               valid
);

  rnc14_pkg::slot_t mem [CHANNELS];
  rnc14_pkg::slot_t rdata;
  logic             rvalid;

  // Storage write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rdata <= mem[rd_addr];
  end

  // Entry valid bits; an entry not valid reads as an empty slot
  always_ff @(posedge clk) begin
    if (rst) begin
      valid  <= '0;
      rvalid <= 1'b0;
    end else begin
      rvalid <= valid[rd_addr];
      if (wr_en) begin
        valid[wr_addr] <= 1'b1;
      end else if (clr_en) begin
        valid[wr_addr] <= 1'b0;
      end
    end
  end

  assign rd_data = rvalid ? rdata : '0;

endmodule

// ===== src/rnc14_slot_logic.sv =====
// Slot update rules and the pieces an event or a flush produces from one slot.
module rnc14_slot_logic (
  input  rnc14_pkg::slot_t                      slot,
  input  logic                                  flush,
  input  logic                                  bypass,
  input  logic [rnc14_pkg::BYTE_BITS-1:0]       controller,
  input  logic [rnc14_pkg::BYTE_BITS-1:0]       ctl_value,
  output rnc14_pkg::upd_t                       upd,
  output rnc14_pkg::piece_list_t                pieces
);

  function automatic logic slot_full(input rnc14_pkg::slot_t s);
    return (s.pm_v || s.pl_v) && s.vm_v && s.vl_v;
  endfunction

  function automatic logic [rnc14_pkg::WORD_BITS-1:0] pair14(
    input logic mv, input logic [rnc14_pkg::BYTE_BITS-1:0] m,
    input logic lv, input logic [rnc14_pkg::BYTE_BITS-1:0] l);
    logic [rnc14_pkg::WORD_BITS-1:0] r;
    r = '0;
    if (lv) begin
      r = mv ? {m, l} : {{rnc14_pkg::BYTE_BITS{1'b0}}, l};
    end else if (mv) begin
      r = {{rnc14_pkg::BYTE_BITS{1'b0}}, m};
    end
    return r;
  endfunction

  function automatic rnc14_pkg::piece_t mk_cc(input logic [rnc14_pkg::BYTE_BITS-1:0] c,
                                              input logic [rnc14_pkg::BYTE_BITS-1:0] v);
    rnc14_pkg::piece_t r;
    r.kind  = rnc14_pkg::KIND_CC;
    r.param = {{rnc14_pkg::BYTE_BITS{1'b0}}, c};
    r.value = {{rnc14_pkg::BYTE_BITS{1'b0}}, v};
    return r;
  endfunction

  // Pieces that leave when a slot is emitted, in emission order
  function automatic rnc14_pkg::piece_list_t slot_pieces(input rnc14_pkg::slot_t s);
    rnc14_pkg::piece_list_t r;
    logic [rnc14_pkg::BYTE_BITS-1:0] cm;
    logic [rnc14_pkg::BYTE_BITS-1:0] cl;
    r  = '0;
    cm = (s.typ == rnc14_pkg::TYPE_RPN) ? rnc14_pkg::CTL_RPN_MSB : rnc14_pkg::CTL_NRPN_MSB;
    cl = (s.typ == rnc14_pkg::TYPE_RPN) ? rnc14_pkg::CTL_RPN_LSB : rnc14_pkg::CTL_NRPN_LSB;
    case (s.typ)
      rnc14_pkg::TYPE_NONE: begin
        r = '0;
      end
      rnc14_pkg::TYPE_CC14: begin
        if (slot_full(s)) begin
          r.p[0].kind  = rnc14_pkg::KIND_CC14;
          r.p[0].param = {{rnc14_pkg::BYTE_BITS{1'b0}}, s.pm};
          r.p[0].value = {s.vm, s.vl};
          r.mask[0]    = 1'b1;
        end else begin
          r.p[0]    = mk_cc(s.pm, s.vm);
          r.mask[0] = s.vm_v;
          r.p[1]    = mk_cc(s.pl, s.vl);
          r.mask[1] = s.vl_v;
        end
      end
      default: begin
        if ((s.pm_v || s.pl_v) && (s.vm_v || s.vl_v)) begin
          // complete parameter/value group
          r.p[0].kind  = rnc14_pkg::kind_t'(s.typ);
          r.p[0].param = pair14(s.pm_v, s.pm, s.pl_v, s.pl);
          r.p[0].value = pair14(s.vm_v, s.vm, s.vl_v, s.vl);
          r.mask[0]    = 1'b1;
        end else begin
          r.p[0]    = mk_cc(cm, s.pm);
          r.mask[0] = s.pm_v;
          r.p[1]    = mk_cc(cl, s.pl);
          r.mask[1] = s.pl_v;
          r.p[2]    = mk_cc(rnc14_pkg::CTL_DATA_MSB, s.vm);
          r.mask[2] = s.vm_v;
          r.p[3]    = mk_cc(rnc14_pkg::CTL_DATA_LSB, s.vl);
          r.mask[3] = s.vl_v;
        end
      end
    endcase
    return r;
  endfunction

  rnc14_pkg::slot_t      m;
  rnc14_pkg::slot_t      esrc;
  rnc14_pkg::slot_type_t ptyp;
  logic                  emit;
  logic                  pass;
  logic                  clash;
  logic                  hi;
  logic                  any;
  logic                  is_psel;
  logic                  is_data;
  logic                  is_msb;
  logic                  is_lsb;
  logic [rnc14_pkg::BYTE_BITS-1:0] partner;

  // Controller decode
  assign any     = slot.pm_v || slot.pl_v || slot.vm_v || slot.vl_v;
  assign is_psel = (controller == rnc14_pkg::CTL_RPN_MSB) ||
                   (controller == rnc14_pkg::CTL_RPN_LSB) ||
                   (controller == rnc14_pkg::CTL_NRPN_MSB) ||
                   (controller == rnc14_pkg::CTL_NRPN_LSB);
  assign is_data = (controller == rnc14_pkg::CTL_DATA_MSB) ||
                   (controller == rnc14_pkg::CTL_DATA_LSB);
  assign is_msb  = (controller[6:5] == 2'b00) && (controller[4:0] != 5'd0);
  assign is_lsb  = (controller[6:5] == 2'b01) && (controller[4:0] != 5'd0);

  // Slot rules
  always_comb begin
    m       = slot;
    esrc    = slot;
    emit    = 1'b0;
    pass    = 1'b0;
    clash   = 1'b0;
    hi      = 1'b0;
    ptyp    = rnc14_pkg::TYPE_RPN;
    partner = '0;
    upd     = '0;
    if (flush) begin
      emit    = 1'b1;
      upd.clr = 1'b1;
    end else if (bypass) begin
      pass = 1'b1;
    end else if (is_psel) begin
      // parameter select
      ptyp  = ((controller == rnc14_pkg::CTL_RPN_MSB) ||
               (controller == rnc14_pkg::CTL_RPN_LSB)) ? rnc14_pkg::TYPE_RPN
                                                       : rnc14_pkg::TYPE_NRPN;
      hi    = (controller == rnc14_pkg::CTL_RPN_MSB) ||
              (controller == rnc14_pkg::CTL_NRPN_MSB);
      clash = (hi ? slot.pm_v : slot.pl_v) || (any && (slot.typ != ptyp));
      m     = clash ? '0 : slot;
      if (m.typ == rnc14_pkg::TYPE_NONE) begin
        m.typ = ptyp;
      end
      if (hi) begin
        m.pm   = ctl_value;
        m.pm_v = 1'b1;
      end else begin
        m.pl   = ctl_value;
        m.pl_v = 1'b1;
      end
      emit      = clash;
      upd.wr_en = 1'b1;
      upd.wdata = m;
    end else if (is_data) begin
      // data entry
      hi = (controller == rnc14_pkg::CTL_DATA_MSB);
      if (slot.typ == rnc14_pkg::TYPE_NONE) begin
        pass = 1'b1;
      end else if ((hi ? slot.vm_v : slot.vl_v) || (slot.typ == rnc14_pkg::TYPE_CC14)) begin
        emit    = 1'b1;
        upd.clr = 1'b1;
        pass    = 1'b1;
      end else begin
        if (hi) begin
          m.vm   = ctl_value;
          m.vm_v = 1'b1;
        end else begin
          m.vl   = ctl_value;
          m.vl_v = 1'b1;
        end
        if (slot_full(m)) begin
          emit    = 1'b1;
          esrc    = m;
          upd.clr = 1'b1;
        end else begin
          upd.wr_en = 1'b1;
          upd.wdata = m;
        end
      end
    end else if (is_msb || is_lsb) begin
      // 14-bit controller halves
      if (is_msb) begin
        partner = controller + rnc14_pkg::CC14_LSB_OFS;
        clash   = slot.pm_v || slot.vm_v ||
                  (any && (slot.typ != rnc14_pkg::TYPE_CC14)) ||
                  ((slot.typ == rnc14_pkg::TYPE_CC14) && (slot.pl != partner));
      end else begin
        partner = controller - rnc14_pkg::CC14_LSB_OFS;
        clash   = slot.pl_v || slot.vl_v ||
                  (any && (slot.typ != rnc14_pkg::TYPE_CC14)) ||
                  ((slot.typ == rnc14_pkg::TYPE_CC14) && (slot.pm != partner));
      end
      m     = clash ? '0 : slot;
      m.typ = rnc14_pkg::TYPE_CC14;
      if (is_msb) begin
        m.pm   = controller;
        m.pm_v = 1'b1;
        m.vm   = ctl_value;
        m.vm_v = 1'b1;
      end else begin
        m.pl   = controller;
        m.pl_v = 1'b1;
        m.vl   = ctl_value;
        m.vl_v = 1'b1;
      end
      emit = clash;
      if (slot_full(m)) begin
        emit    = 1'b1;
        esrc    = m;
        upd.clr = 1'b1;
      end else begin
        upd.wr_en = 1'b1;
        upd.wdata = m;
      end
    end else begin
      pass = 1'b1;
    end
  end

  // Emitted slot pieces followed by the pass-through event
  always_comb begin
    pieces = emit ? slot_pieces(esrc) : '0;
    pieces.p[rnc14_pkg::PASS_IDX]    = mk_cc(controller, ctl_value);
    pieces.mask[rnc14_pkg::PASS_IDX] = pass;
  end

endmodule

// ===== src/midi_rpn_nrpn_cc14_assembler_top.sv =====
// Top level: sequencer around the channel slot memory and the result register.
// Event: accepted, slot read-modify-write in the next cycle, first result strobed in the
// cycle after that; each further result is sent from the emit state. Busy holds off a new
// event until the last result is registered. Flush: walks every channel slot in turn and
// emits the pieces of each occupied slot, clearing it.
// Synchronous reset empties every slot through per-entry valid bits; no clearing pass.
module midi_rpn_nrpn_cc14_assembler_top #(
  parameter int CHANNELS = rnc14_pkg::CHANNELS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic                                opcode,
  input  logic [rnc14_pkg::CH_BITS-1:0]       channel,
  input  logic [rnc14_pkg::BYTE_BITS-1:0]     controller,
  input  logic [rnc14_pkg::BYTE_BITS-1:0]     ctl_value,
  output logic                                result_strobe,
  output logic [1:0]                          kind,
  output logic [rnc14_pkg::CH_BITS-1:0]       out_channel,
  output logic [rnc14_pkg::WORD_BITS-1:0]     out_param,
  output logic [rnc14_pkg::WORD_BITS-1:0]     out_value,
  output logic                                last
);

  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int NP    = rnc14_pkg::NPIECES;

  rnc14_pkg::state_t      state;
  rnc14_pkg::state_t      state_next;
  rnc14_pkg::slot_t       rd_data;
  rnc14_pkg::upd_t        upd;
  rnc14_pkg::piece_list_t lst;
  rnc14_pkg::piece_list_t src;
  rnc14_pkg::piece_t      sel_piece;
  rnc14_pkg::piece_t [NP-1:0] pend;

  logic [rnc14_pkg::CH_BITS-1:0]   ch_r;
  logic [rnc14_pkg::BYTE_BITS-1:0] ctl_r;
  logic [rnc14_pkg::BYTE_BITS-1:0] val_r;
  logic                            fl_mode;
  logic [IDX_W-1:0]                flush_idx;
  logic [NP-1:0]                   pend_mask;
  logic [NP-1:0]                   sel_oh;
  logic [NP-1:0]                   rest;
  logic [CHANNELS-1:0]             valid;
  logic [CHANNELS-1:0]             later_bits;
  logic [IDX_W-1:0]                rd_addr;
  logic [IDX_W-1:0]                wr_addr;
  logic [rnc14_pkg::CH_BITS-1:0]   chan_sel;
  logic accept;
  logic in_range;
  logic idx_last;
  logic later;
  logic mem_wr;
  logic mem_clr;
  logic strobe_next;
  logic last_next;
  logic advance;

  assign accept   = start && !busy;
  assign in_range = ({1'b0, ch_r} < (rnc14_pkg::CH_BITS + 1)'(CHANNELS));
  assign idx_last = (flush_idx == IDX_W'(CHANNELS - 1));

  rnc14_slot_mem #(
    .CHANNELS(CHANNELS)
  ) u_mem (
    .clk     (clk),
    .rst     (rst),
    .rd_addr (rd_addr),
    .wr_en   (mem_wr),
    .clr_en  (mem_clr),
    .wr_addr (wr_addr),
    .wr_data (upd.wdata),
    .rd_data (rd_data),
    .valid   (valid)
  );

  rnc14_slot_logic u_logic (
    .slot       (rd_data),
    .flush      (state == rnc14_pkg::ST_FEVAL),
    .bypass     (!in_range),
    .controller (ctl_r),
    .ctl_value  (val_r),
    .upd        (upd),
    .pieces     (lst)
  );

  // Occupied slots above the one being flushed
  always_comb begin
    for (int i = 0; i < CHANNELS; i++) begin
      later_bits[i] = valid[i] && (flush_idx < IDX_W'(i));
    end
  end
  assign later = |later_bits;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      rnc14_pkg::ST_IDLE: begin
        if (start) begin
          state_next = (opcode == rnc14_pkg::OP_FLUSH) ? rnc14_pkg::ST_FEVAL
                                                       : rnc14_pkg::ST_EVAL;
        end
      end
      rnc14_pkg::ST_EVAL: begin
        state_next = (|rest) ? rnc14_pkg::ST_EMIT : rnc14_pkg::ST_IDLE;
      end
      rnc14_pkg::ST_FEVAL: begin
        if (|rest) begin
          state_next = rnc14_pkg::ST_EMIT;
        end else begin
          state_next = idx_last ? rnc14_pkg::ST_IDLE : rnc14_pkg::ST_FEVAL;
        end
      end
      rnc14_pkg::ST_EMIT: begin
        if (|rest) begin
          state_next = rnc14_pkg::ST_EMIT;
        end else if (fl_mode && !idx_last) begin
          state_next = rnc14_pkg::ST_FEVAL;
        end else begin
          state_next = rnc14_pkg::ST_IDLE;
        end
      end
      default: state_next = rnc14_pkg::ST_IDLE;
    endcase
  end

  // Outputs of the sequencer: memory control, piece selection, result strobe
  always_comb begin
    busy     = (state != rnc14_pkg::ST_IDLE);
    src      = '0;
    rd_addr  = ch_r[IDX_W-1:0];
    wr_addr  = ch_r[IDX_W-1:0];
    mem_wr   = 1'b0;
    mem_clr  = 1'b0;
    chan_sel = ch_r;
    case (state)
      rnc14_pkg::ST_IDLE: begin
        rd_addr = (opcode == rnc14_pkg::OP_FLUSH) ? '0 : channel[IDX_W-1:0];
      end
      rnc14_pkg::ST_EVAL: begin
        src     = lst;
        mem_wr  = upd.wr_en && in_range;
        mem_clr = upd.clr && in_range;
      end
      rnc14_pkg::ST_FEVAL: begin
        src      = lst;
        rd_addr  = idx_last ? '0 : flush_idx + 1'b1;
        wr_addr  = flush_idx;
        mem_clr  = upd.clr;
        chan_sel = rnc14_pkg::CH_BITS'(flush_idx);
      end
      rnc14_pkg::ST_EMIT: begin
        src.p    = pend;
        src.mask = pend_mask;
        rd_addr  = idx_last ? '0 : flush_idx + 1'b1;
      end
      default: begin
        src = '0;
      end
    endcase

    // lowest pending piece goes out first
    sel_oh    = src.mask & (~src.mask + NP'(1));
    rest      = src.mask & ~sel_oh;
    sel_piece = '0;
    for (int i = 0; i < NP; i++) begin
      sel_piece = sel_piece | (sel_oh[i] ? src.p[i] : '0);
    end
    strobe_next = |src.mask;
    last_next   = !(|rest) && !(fl_mode && later);
    advance     = fl_mode && !(|rest) && !idx_last &&
                  ((state == rnc14_pkg::ST_FEVAL) || (state == rnc14_pkg::ST_EMIT));
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= rnc14_pkg::ST_IDLE;
      result_strobe <= 1'b0;
    end else begin
      state         <= state_next;
      result_strobe <= strobe_next;
    end
  end

  // Transaction fields, flush walk index and pending pieces
  always_ff @(posedge clk) begin
    if (accept) begin
      ch_r      <= channel;
      ctl_r     <= controller;
      val_r     <= ctl_value;
      fl_mode   <= (opcode == rnc14_pkg::OP_FLUSH);
      flush_idx <= '0;
    end else if (advance) begin
      flush_idx <= flush_idx + 1'b1;
    end
    if ((state == rnc14_pkg::ST_EVAL) || (state == rnc14_pkg::ST_FEVAL)) begin
      pend <= lst.p;
    end
    pend_mask <= rest;
  end

  // Result register
  always_ff @(posedge clk) begin
    if (strobe_next) begin
      kind      <= sel_piece.kind;
      out_param <= sel_piece.param;
      out_value <= sel_piece.value;
      last      <= last_next;
      if (state != rnc14_pkg::ST_EMIT) begin
        out_channel <= chan_sel;
      end
    end
  end

endmodule
